@@ rtl/assert_macros.svh @@
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, clocked, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication check
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ rtl/tdl_pkg.sv @@
`default_nettype none
package tdl_pkg;

    localparam int COARSE_SHIFT = 3;
    localparam int TRACE_LEN    = 20;
    localparam int FIELD_WIDTH  = 160;
    localparam int FIELD_HEIGHT = 128;
    localparam int GRID_W       = FIELD_WIDTH >> COARSE_SHIFT;
    localparam int GRID_H       = FIELD_HEIGHT >> COARSE_SHIFT;
    localparam int WB           = $clog2(GRID_W);
    localparam int HB           = $clog2(GRID_H);
    localparam int TIX_W        = $clog2(TRACE_LEN);

    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_NONE  = 2'd3;

    localparam logic [2:0] REG_ROUTING  = 3'd0;
    localparam logic [2:0] REG_DISCOUNT = 3'd1;
    localparam logic [2:0] REG_REWARD   = 3'd2;
    localparam logic [2:0] REG_LEARN    = 3'd3;
    localparam logic [2:0] REG_DECAY    = 3'd4;
    localparam logic [2:0] REG_GREEDY   = 3'd5;

    localparam logic signed [31:0] Q_MIN = 32'sd1638;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [19:0]        event_key;
        logic [14:0]        rand_greedy;
        logic [14:0]        rand_count;
        logic [14:0]        rand_choice;
        logic [15:0]        table_addr;
        logic signed [31:0] table_data;
    } t_in;

    typedef struct packed {
        logic        press_valid;
        logic [31:0] press_word;
        logic [1:0]  chosen_action;
        logic        learned;
    } t_out;

    typedef struct packed {
        logic [31:0] routing_key;
        logic [15:0] discount;
        logic [15:0] reward_weight;
        logic [15:0] learn_rate;
        logic [15:0] trace_decay;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture item, decode event / tick / write
        logic       rd_q;      // read q for action in act
        logic [1:0] act;
        logic       lat_q;     // latch q read data
        logic       choose;
        logic       delta0;    // delta stage 0
        logic       delta1;
        logic       shift;     // trace shift, delta
        logic       step1;
        logic       slot_rd;   // read q for slot
        logic       slot_mul;  // step*elig
        logic       slot_wr;   // write back + decay
        logic [TIX_W-1:0] slot;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic       learn;      // event requires learning step
        logic       slot_valid;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/tdl_ctrl.sv @@
`default_nettype none
module tdl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tdl_pkg::t_sts i_sts,
    output tdl_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import tdl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_QRD   = 4'd2;
    localparam logic [3:0] S_CHOOSE= 4'd3;
    localparam logic [3:0] S_D0    = 4'd4;
    localparam logic [3:0] S_D1    = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_STEP  = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SMUL  = 4'd9;
    localparam logic [3:0] S_SWR   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_act, n_act;
    logic [TIX_W-1:0] r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_slot  = r_slot;
        o_cmd   = '0;
        o_cmd.act  = r_act;
        o_cmd.slot = r_slot;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.learn) begin
                    n_act = 2'd0;
                    o_cmd.act = 2'd0;
                    o_cmd.rd_q = 1'b1;
                    n_state = S_QRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QRD: begin
                // read data for r_act arrives this cycle
                o_cmd.lat_q = 1'b1;
                if (r_act == 2'd2) begin
                    n_state = S_CHOOSE;
                end else begin
                    n_act = r_act + 2'd1;
                    o_cmd.rd_q = 1'b1;
                    o_cmd.act = r_act + 2'd1;
                end
            end
            S_CHOOSE: begin
                o_cmd.choose = 1'b1;
                n_state = S_D0;
            end
            S_D0: begin
                o_cmd.delta0 = 1'b1;
                n_state = S_D1;
            end
            S_D1: begin
                o_cmd.delta1 = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.step1 = 1'b1;
                n_slot = TIX_W'(1);
                n_state = S_SRD;
            end
            S_SRD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                o_cmd.slot_mul = 1'b1;
                n_state = S_SWR;
            end
            S_SWR: begin
                o_cmd.slot_wr = 1'b1;
                if (r_slot == TIX_W'(TRACE_LEN - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + TIX_W'(1);
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/tdl_dpath.sv @@
`default_nettype none
module tdl_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tdl_pkg::t_in  i_item,
    input  wire tdl_pkg::t_cfg i_cfg,
    input  wire logic          i_greedy_ld,
    input  wire logic [15:0]   i_greedy_val,
    input  wire tdl_pkg::t_cmd i_cmd,
    output tdl_pkg::t_sts      o_sts,
    output tdl_pkg::t_out      o_res
);
    import tdl_pkg::*;

    logic signed [31:0] r_mem [0:65535];
    logic signed [31:0] r_rd;
    logic [1:0]  r_rd_act;
    logic [15:0] mem_raddr;

    t_in r_it;
    logic [WB-1:0] r_bat_col, r_ball_col;
    logic [HB-1:0] r_ball_row;
    logic [2*WB+HB-1:0] r_last;
    logic [15:0] r_rew, r_pen, r_greedy;
    logic [6:0]  r_moves;
    logic [1:0]  r_dir;
    logic signed [31:0] r_cur_q, r_prev_q, r_ql, r_qr, r_qn;
    logic [15:0] r_cur_idx;
    logic [14:0] r_tick;
    logic        r_learn, r_learned;
    logic [TRACE_LEN-1:0] r_tv;
    logic [15:0] r_tl [0:TRACE_LEN-1];
    logic signed [47:0] r_p0;
    logic signed [63:0] r_p1;
    logic signed [31:0] r_delta, r_step, r_elig, r_inc;
    logic signed [31:0] r_slot_q;
    logic [15:0] r_slot_addr;
    logic        r_press;
    logic [31:0] r_word;

    function automatic logic [15:0] qidx(input logic [1:0] a, input logic [WB-1:0] bc,
                                         input logic [HB-1:0] br, input logic [WB-1:0] cc);
        logic [31:0] s;
        s = 32'(bc) | (32'(br) << WB) | (32'(cc) << (WB + HB));
        s = s + (32'(a) << (2 * WB + HB));
        return s[15:0];
    endfunction

    function automatic logic signed [63:0] fq15(input logic signed [63:0] v);
        return v >>> 15;
    endfunction

    // event decode
    logic [19:0] k;
    logic [7:0]  ky, kx;
    logic [WB-1:0] nb_bat, nb_bcol;
    logic [HB-1:0] nb_brow;
    logic [2*WB+HB-1:0] npos;
    always_comb begin
        k  = i_item.event_key;
        ky = k[8:1];
        kx = k[16:9];
        nb_bat = r_bat_col; nb_bcol = r_ball_col; nb_brow = r_ball_row;
        if (k[0]) begin
            if (ky == 8'(FIELD_HEIGHT)) begin
                if (32'(kx) > ((GRID_W - 1) << COARSE_SHIFT)) nb_bat = WB'(GRID_W - 1);
                else nb_bat = WB'(kx >> COARSE_SHIFT);
            end else begin
                if (ky == 8'd0) nb_brow = '0;
                else if (32'((ky - 8'd1) >> COARSE_SHIFT) > GRID_H - 1)
                    nb_brow = HB'(GRID_H - 1);
                else nb_brow = HB'((ky - 8'd1) >> COARSE_SHIFT);
                if (32'(kx >> COARSE_SHIFT) > GRID_W - 1) nb_bcol = WB'(GRID_W - 1);
                else nb_bcol = WB'(kx >> COARSE_SHIFT);
            end
        end
        npos = {nb_bcol, nb_brow, nb_bat};
    end

    assign o_sts.learn = r_learn;
    assign o_sts.slot_valid = r_tv[i_cmd.slot];

    always_comb begin
        mem_raddr = qidx(i_cmd.act, r_bat_col, r_ball_row, r_ball_col);
        if (i_cmd.slot_rd) mem_raddr = r_tl[i_cmd.slot];
    end

    // greedy or random action choice
    logic [1:0] ch_dir;
    logic [6:0] ch_moves;
    logic [21:0] rc_prod;
    always_comb begin
        rc_prod = 22'(r_it.rand_count) * 22'd80;
        if ({1'b0, r_it.rand_greedy} < r_greedy) begin
            ch_moves = 7'd60;
            if (r_ql > r_qr && r_ql > r_qn) ch_dir = DIR_LEFT;
            else if (r_qr > r_ql && r_qr > r_qn) ch_dir = DIR_RIGHT;
            else ch_dir = DIR_NONE;
        end else begin
            ch_moves = 7'(rc_prod >> 15) + 7'd40;
            if (r_it.rand_choice < 15'd13107) ch_dir = DIR_LEFT;
            else if (r_it.rand_choice < 15'd26214) ch_dir = DIR_RIGHT;
            else ch_dir = DIR_NONE;
        end
    end

    logic signed [63:0] nv;
    always_comb begin
        nv = 64'(r_slot_q) + r_p1;
        nv = 64'(sat32(nv));
        if (nv < 64'(Q_MIN)) nv = 64'(Q_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_q || i_cmd.slot_rd) r_rd <= r_mem[mem_raddr];
        if (i_cmd.load && i_item.req_type == REQ_WRITE)
            r_mem[i_item.table_addr] <= i_item.table_data;
        else if (i_cmd.slot_wr && r_tv[i_cmd.slot])
            r_mem[r_slot_addr] <= nv[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_it <= i_item;
        // action of the word now in r_rd
        if (i_cmd.rd_q) r_rd_act <= i_cmd.act;
        if (i_cmd.lat_q) begin
            case (r_rd_act)
                2'd0: r_ql <= r_rd;
                2'd1: r_qr <= r_rd;
                default: r_qn <= r_rd;
            endcase
        end
        if (i_cmd.delta0)
            r_p0 <= 48'(signed'({1'b0, i_cfg.reward_weight})) *
                    (48'sd10 * 48'(signed'({1'b0, r_rew})) - 48'(signed'({1'b0, r_pen})));
        if (i_cmd.delta1)
            r_p1 <= 64'(signed'({1'b0, i_cfg.discount})) * 64'(r_prev_q);
        if (i_cmd.shift) begin
            r_delta <= sat32(64'(r_p0) + fq15(r_p1) - 64'(r_cur_q));
            for (int i = TRACE_LEN - 1; i > 0; i--) r_tl[i] <= r_tl[i - 1];
            r_tl[0] <= r_cur_idx;
        end
        if (i_cmd.step1) begin
            r_step <= sat32(fq15(64'(signed'({1'b0, i_cfg.learn_rate})) * 64'(r_delta)));
            r_elig <= 32'sd32768;
        end
        if (i_cmd.slot_rd) r_slot_addr <= r_tl[i_cmd.slot];
        if (i_cmd.slot_mul) begin
            r_slot_q <= r_rd;
            r_p1 <= fq15(64'(r_step) * 64'(r_elig));
        end
        if (i_cmd.slot_wr)
            r_elig <= sat32(fq15(64'(r_elig) * 64'(signed'({1'b0, i_cfg.trace_decay}))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bat_col <= WB'(1); r_ball_col <= WB'(1); r_ball_row <= HB'(8);
            r_last <= '0; r_rew <= '0; r_pen <= '0; r_moves <= '0;
            r_dir <= DIR_LEFT; r_cur_q <= '0; r_prev_q <= '0; r_cur_idx <= '0;
            r_greedy <= 16'd16384; r_tick <= '0; r_learn <= 1'b0; r_learned <= 1'b0;
            r_tv <= '0; r_press <= 1'b0; r_word <= '0;
        end else begin
            if (i_greedy_ld) r_greedy <= i_greedy_val;
            if (i_cmd.load) begin
                r_learn <= 1'b0; r_learned <= 1'b0; r_press <= 1'b0; r_word <= '0;
                case (i_item.req_type)
                    REQ_EVENT: begin
                        if (i_item.event_key == 20'd0) begin
                            if (r_rew != 16'hffff) r_rew <= r_rew + 16'd1;
                        end else if (i_item.event_key == 20'd1) begin
                            if (r_pen != 16'hffff) r_pen <= r_pen + 16'd1;
                        end else begin
                            r_bat_col <= nb_bat; r_ball_col <= nb_bcol; r_ball_row <= nb_brow;
                            if (npos != r_last) begin
                                r_last <= npos; r_learn <= 1'b1; r_learned <= 1'b1;
                            end
                        end
                    end
                    REQ_TICK: begin
                        if (r_moves != 7'd0 && (r_dir == DIR_LEFT || r_dir == DIR_RIGHT)) begin
                            r_press <= 1'b1;
                            r_word <= i_cfg.routing_key | 32'(r_dir);
                            r_moves <= r_moves - 7'd1;
                        end
                        if (r_tick == 15'd20000) begin
                            r_tick <= '0;
                            if (r_greedy < 16'd29491) r_greedy <= r_greedy + 16'd3;
                        end else begin
                            r_tick <= r_tick + 15'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.choose) begin
                r_dir <= ch_dir; r_moves <= ch_moves;
                r_cur_q <= (ch_dir == DIR_LEFT) ? r_ql :
                           (ch_dir == DIR_RIGHT) ? r_qr : r_qn;
                r_cur_idx <= qidx(ch_dir - 2'd1, r_bat_col, r_ball_row, r_ball_col);
            end
            if (i_cmd.shift) r_tv <= {r_tv[TRACE_LEN-2:0], 1'b1};
            if (i_cmd.finish && r_learned) begin
                r_prev_q <= r_cur_q;
                r_rew <= '0; r_pen <= '0;
            end
        end
    end

    assign o_res.press_valid   = r_press;
    assign o_res.press_word    = r_word;
    assign o_res.chosen_action = r_dir;
    assign o_res.learned       = r_learned;

endmodule
`default_nettype wire

@@ rtl/td_lambda_q_learning_agent_unit.sv @@
// channel | dir | payload              | handshake
// in      | in  | tdl_pkg::t_in        | i_in_valid / o_in_stall
// out     | out | tdl_pkg::t_out       | o_out_valid / i_out_stall
// cfg     | in  | apb, 32-bit data     | psel / penable / pready
// one item in flight; ticks, writes and non-learning events skip the q update,
// while a learning step walks the q memory once per trace slot after slot 0,
// reading, multiplying and writing back each slot in turn
// reset is synchronous, active low; the q memory is not cleared
// the result waits in an output register; the next item is taken once it is gone
`default_nettype none
module td_lambda_q_learning_agent_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire tdl_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tdl_pkg::t_out       o_out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tdl_pkg::*;

    t_cfg r_cfg;
    logic [15:0] r_gstart;
    t_cmd cmd;
    t_sts sts;
    t_out res;
    logic busy, done, start, wr, r_ov;
    t_out r_od;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.routing_key <= '0; r_cfg.discount <= 16'd29491;
            r_cfg.reward_weight <= 16'd3277; r_cfg.learn_rate <= 16'd164;
            r_cfg.trace_decay <= 16'd31130; r_gstart <= 16'd16384;
        end else if (wr) begin
            case (ridx)
                REG_ROUTING:  r_cfg.routing_key <= pwdata;
                REG_DISCOUNT: r_cfg.discount <= pwdata[15:0];
                REG_REWARD:   r_cfg.reward_weight <= pwdata[15:0];
                REG_LEARN:    r_cfg.learn_rate <= pwdata[15:0];
                REG_DECAY:    r_cfg.trace_decay <= pwdata[15:0];
                REG_GREEDY:   r_gstart <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_ROUTING:  prdata = r_cfg.routing_key;
            REG_DISCOUNT: prdata = 32'(r_cfg.discount);
            REG_REWARD:   prdata = 32'(r_cfg.reward_weight);
            REG_LEARN:    prdata = 32'(r_cfg.learn_rate);
            REG_DECAY:    prdata = 32'(r_cfg.trace_decay);
            REG_GREEDY:   prdata = 32'(r_gstart);
            default:      prdata = '0;
        endcase
    end

    assign o_in_stall = busy || r_ov;
    assign start = i_in_valid && !o_in_stall;

    tdl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(sts),
        .o_cmd(cmd), .o_busy(busy), .o_done(done)
    );

    tdl_dpath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_data), .i_cfg(r_cfg),
        .i_greedy_ld(wr && ridx == REG_GREEDY), .i_greedy_val(pwdata[15:0]),
        .i_cmd(cmd), .o_sts(sts), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (done) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_od <= res;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule
`default_nettype wire

@@ rtl/tdl_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module tdl_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire tdl_pkg::t_out o_out_data,
    input wire logic          pready
);
    `CHK_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `CHK_IMPL(a_no_take_full, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `CHK_IMPL(a_press_word, i_clk, i_rst_n, o_out_valid && !o_out_data.press_valid, o_out_data.press_word == 32'd0)
    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid)
endmodule

bind td_lambda_q_learning_agent_unit tdl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
    .pready(pready)
);
`default_nettype wire
